// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache core: default sizes,
// operation codes, controller states and the controller command bundle.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES_DEF   = 8;
   localparam int KEY_BITS_DEF  = 16;
   localparam int DATA_BITS_DEF = 32;
   localparam int CSR_BITS      = 4;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic cfg_write;
   } cmd_type;

endpackage

// File: hdl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Controller: request and configuration handshakes, two-state sequencer and
// the response valid flag in front of the output register.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_valid,
   output logic             csr_ready,
   output lkvc_pkg::cmd_type cmd
);

   lkvc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      req_tready    = 1'b0;
      csr_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            csr_ready  = 1'b1;
            req_tready = ~csr_valid;
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
            end else if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = lkvc_pkg::ST_UPDATE;
            end
         end
         lkvc_pkg::ST_UPDATE: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lkvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hdl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// lkvc_datapath
// Datapath: entry keys, valid bits and recency ranks, parallel key compare,
// victim selection, rank update, value memory and response register.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
   parameter int ENTRIES   = lkvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS  = lkvc_pkg::KEY_BITS_DEF,
   parameter int DATA_BITS = lkvc_pkg::DATA_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::cmd_type             cmd,
   input  logic                          req_op,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [DATA_BITS-1:0]          req_value,
   input  logic [lkvc_pkg::CSR_BITS-1:0] csr_data,
   output logic                          rsp_hit,
   output logic [DATA_BITS-1:0]          rsp_data
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   logic [CNT_BITS-1:0]  count_ff, cfg_count;
   logic [ENTRIES-1:0]   valid_ff, active_vec;
   logic [KEY_BITS-1:0]  key_ff  [ENTRIES];
   logic [IDX_BITS-1:0]  rank_ff [ENTRIES];
   logic [IDX_BITS-1:0]  rank_in [ENTRIES];
   logic [DATA_BITS-1:0] data_mem [ENTRIES];
   logic [IDX_BITS-1:0]  last_rank;

   lkvc_pkg::op_type     op_ff;
   logic [KEY_BITS-1:0]  key_req_ff;
   logic [DATA_BITS-1:0] value_ff;
   logic [ENTRIES-1:0]   match_ff, match_in;
   logic [ENTRIES-1:0]   empty_ff, empty_in;
   logic [ENTRIES-1:0]   oldest_ff, oldest_in;

   logic                 hit, full, is_put, fill, do_update;
   logic [ENTRIES-1:0]   empty_low, target;
   logic [IDX_BITS-1:0]  target_idx, target_rank;

   logic                 rsp_hit_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;

   // clamp of the written entry count
   always_comb begin
      if (csr_data == '0) begin
         cfg_count = CNT_BITS'(1);
      end else if (32'(csr_data) > ENTRIES) begin
         cfg_count = CNT_BITS'(ENTRIES);
      end else begin
         cfg_count = CNT_BITS'(csr_data);
      end
   end

   // compare stage
   assign last_rank = IDX_BITS'(count_ff - CNT_BITS'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         active_vec[i] = CNT_BITS'(i) < count_ff;
         match_in[i]   = valid_ff[i] & active_vec[i] & (key_ff[i] == req_key);
         empty_in[i]   = ~valid_ff[i] & active_vec[i];
         oldest_in[i]  = valid_ff[i] & (rank_ff[i] == last_rank);
      end
   end

   // update stage
   assign hit       = |match_ff;
   assign full      = ~|empty_ff;
   assign is_put    = op_ff == lkvc_pkg::OP_PUT;
   assign fill      = is_put & ~hit & ~full;
   assign do_update = hit | is_put;
   assign empty_low = empty_ff & (~empty_ff + ENTRIES'(1));
   assign target    = hit ? match_ff : (full ? oldest_ff : empty_low);

   always_comb begin
      target_idx  = '0;
      target_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (target[i]) begin
            target_idx  = target_idx | IDX_BITS'(i);
            target_rank = target_rank | rank_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (target[i]) begin
            rank_in[i] = '0;
         end else if (valid_ff[i] && (fill || rank_ff[i] < target_rank)) begin
            rank_in[i] = rank_ff[i] + IDX_BITS'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= CNT_BITS'(ENTRIES);
      end else if (cmd.cfg_write) begin
         valid_ff <= '0;
         count_ff <= cfg_count;
      end else if (cmd.commit && fill) begin
         valid_ff <= valid_ff | target;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= lkvc_pkg::op_type'(req_op);
         key_req_ff <= req_key;
         value_ff   <= req_value;
         match_ff   <= match_in;
         empty_ff   <= empty_in;
         oldest_ff  <= oldest_in;
      end
      if (cmd.commit && do_update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
            if (target[i] && is_put && !hit) begin
               key_ff[i] <= key_req_ff;
            end
         end
      end
   end

   // value memory with registered read into the response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (is_put) begin
            data_mem[target_idx] <= value_ff;
         end
         rsp_hit_ff  <= hit;
         rsp_data_ff <= (!is_put && hit) ? data_mem[target_idx] : '0;
      end
   end

   assign rsp_hit  = rsp_hit_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: hdl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request is a get or a put of one key: the accept cycle registers a
// parallel compare of the key against every entry, and the update cycle picks
// the matching, lowest empty or least recent entry, updates the recency ranks
// on a hit or a put, writes the value memory on a put and loads the response
// register. A new request is accepted only after the last one has passed its
// update cycle, which a held response stalls. A write on the csr channel sets
// the number of entries in use (zero reads as one, values above ENTRIES as
// ENTRIES) and empties the cache. The value memory needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
   parameter int ENTRIES   = lkvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS  = lkvc_pkg::KEY_BITS_DEF,
   parameter int DATA_BITS = lkvc_pkg::DATA_BITS_DEF,
   localparam int REQ_BITS = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((DATA_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_BITS-1:0]           req_tdata,   // key, value
   input  logic                          req_tuser,   // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_BITS-1:0]           rsp_tdata,   // read_value
   output logic                          rsp_tuser,   // hit
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CSR_BITS-1:0] csr_data     // active_entries
);

   lkvc_pkg::cmd_type    cmd;
   logic [DATA_BITS-1:0] rsp_data;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd)
   );

   lkvc_datapath #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_op    (req_tuser),
      .req_key   (req_tdata[KEY_BITS-1:0]),
      .req_value (req_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS]),
      .csr_data  (csr_data),
      .rsp_hit   (rsp_tuser),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = RSP_BITS'(rsp_data);

endmodule
